// ----- sv/wsfp_pkg.sv -----
// shared types and constants for the websocket frame parser
package wsfp_pkg;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_LEN,
        PH_EXT,
        PH_KEY,
        PH_PAY
    } phase_t;

    localparam logic [2:0] EV_HDR_BYTE  = 3'd0;
    localparam logic [2:0] EV_HDR_DONE  = 3'd1;
    localparam logic [2:0] EV_TEXT      = 3'd2;
    localparam logic [2:0] EV_CLOSE     = 3'd3;
    localparam logic [2:0] EV_REASON    = 3'd4;
    localparam logic [2:0] EV_OTHER     = 3'd5;
    localparam logic [2:0] EV_BAD_LEN   = 3'd6;
    localparam logic [2:0] EV_IGNORED   = 3'd7;

    localparam logic [3:0]  OP_TEXT     = 4'h1;
    localparam logic [3:0]  OP_CLOSE    = 4'h8;
    localparam logic [6:0]  LEN7_EXT16  = 7'd126;
    localparam logic [30:0] LEN_LIMIT   = 31'h7fffffff;
    localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
    localparam logic [7:0]  CHAR_DOT    = 8'h2e;
    localparam logic [7:0]  CHAR_TAB    = 8'h09;
    localparam logic [7:0]  CHAR_LF     = 8'h0a;
    localparam logic [7:0]  CHAR_CR     = 8'h0d;
    localparam logic [10:0] LIMIT_RESET = 11'd4;

    typedef struct packed {
        logic       direction;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic        dir_out;
        logic [3:0]  opcode;
        logic        fin;
        logic        masked;
        logic [30:0] payload_length;
        logic [7:0]  out_byte;
        logic [15:0] close_code;
        logic [31:0] frame_count;
        logic [31:0] masked_count;
        logic [30:0] payload_total;
        logic        frame_end;
    } result_t;

endpackage

// ----- sv/wsfp_inq.sv -----
// front: two-entry input queue that takes stream bytes
module wsfp_inq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  wsfp_pkg::item_t item_in,
    output logic           item_valid,
    input  logic           item_take,
    output wsfp_pkg::item_t item_out
);
    import wsfp_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    item_t      mem_reg [2];
    logic       wr, rd;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item_out   = mem_reg[rd_ptr_reg];
    assign wr         = push && !full;
    assign rd         = item_take && item_valid;

    always_comb
    begin
        cnt_next    = cnt_reg + {1'b0, wr} - {1'b0, rd};
        wr_ptr_next = wr_ptr_reg ^ wr;
        rd_ptr_next = rd_ptr_reg ^ rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// ----- sv/wsfp_outq.sv -----
// two-entry result queue facing the consumer
module wsfp_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_write,
    input  wsfp_pkg::result_t res_in,
    output logic             res_full,
    output logic             empty,
    input  logic             pop,
    output wsfp_pkg::result_t res_out
);
    import wsfp_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    result_t    mem_reg [2];
    logic       wr, rd;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign res_out  = mem_reg[rd_ptr_reg];
    assign wr       = res_write && !res_full;
    assign rd       = pop && !empty;

    always_comb
    begin
        cnt_next    = cnt_reg + {1'b0, wr} - {1'b0, rd};
        wr_ptr_next = wr_ptr_reg ^ wr;
        rd_ptr_next = rd_ptr_reg ^ rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= res_in;
    end

endmodule

// ----- sv/wsfp_parse.sv -----
// back: per-direction frame parse state, counters and result build
module wsfp_parse #(
    parameter int SAMPLE_MAX = 256,
    parameter int REASON_MAX = 123
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_limit_we,
    input  logic [10:0]      sample_limit_wdata,
    input  logic             item_valid,
    input  wsfp_pkg::item_t  item,
    output logic             item_take,
    input  logic             res_full,
    output logic             res_write,
    output wsfp_pkg::result_t res
);
    import wsfp_pkg::*;

    // per-direction state
    phase_t      phase_reg  [2];
    logic [3:0]  hidx_reg   [2];
    logic [63:0] flen_reg   [2];
    logic [31:0] key_reg    [2];
    logic [30:0] off_reg    [2];
    logic [3:0]  fop_reg    [2];
    logic [3:0]  lop_reg    [2];
    logic        fin_reg    [2];
    logic        msk_reg    [2];
    logic        samp_reg   [2];
    logic [7:0]  chi_reg    [2];
    // shared state
    logic [31:0] frames_reg, frames_next;
    logic [31:0] mcnt_reg, mcnt_next;
    logic [30:0] total_reg, total_next;
    logic [10:0] samples_reg, samples_next;
    logic [10:0] limit_reg;
    logic        halted_reg, halted_next;

    phase_t      phase_next;
    logic [3:0]  hidx_next, fop_next, lop_next, eff_op;
    logic [63:0] flen_next;
    logic [31:0] key_next, off_inc, total_sum;
    logic [30:0] off_next, off_cur;
    logic        fin_next, msk_next, samp_next;
    logic [7:0]  chi_next, b, keyb, c;
    logic        d, fire, do_after_len, do_finish;
    logic [2:0]  ev;
    logic [15:0] code;
    logic        fend;
    logic [7:0]  obyte;

    assign d         = item.direction;
    assign b         = item.data_byte;
    assign fire      = item_valid && !res_full;
    assign item_take = fire;
    assign res_write = fire;

    always_comb
    begin
        phase_next   = phase_reg[d];
        hidx_next    = hidx_reg[d];
        flen_next    = flen_reg[d];
        key_next     = key_reg[d];
        off_next     = off_reg[d];
        fop_next     = fop_reg[d];
        lop_next     = lop_reg[d];
        fin_next     = fin_reg[d];
        msk_next     = msk_reg[d];
        samp_next    = samp_reg[d];
        chi_next     = chi_reg[d];
        frames_next  = frames_reg;
        mcnt_next    = mcnt_reg;
        total_next   = total_reg;
        samples_next = samples_reg;
        halted_next  = halted_reg;
        do_after_len = 1'b0;
        do_finish    = 1'b0;
        ev           = EV_HDR_BYTE;
        code         = 16'd0;
        fend         = 1'b0;
        obyte        = 8'd0;
        off_cur      = off_reg[d];
        keyb         = 8'd0;
        c            = 8'd0;
        off_inc      = 32'd0;
        total_sum    = 32'd0;

        unique case (phase_reg[d])
            PH_FIRST:
            begin
                fin_next   = b[7];
                msk_next   = 1'b0;
                fop_next   = b[3:0];
                flen_next  = 64'd0;
                key_next   = 32'd0;
                off_next   = 31'd0;
                samp_next  = 1'b0;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (b[7])
                    msk_next = 1'b1;
                if (b[6:0] < LEN7_EXT16)
                begin
                    flen_next    = {57'd0, b[6:0]};
                    do_after_len = 1'b1;
                end
                else
                begin
                    phase_next = PH_EXT;
                    hidx_next  = (b[6:0] == LEN7_EXT16) ? 4'd2 : 4'd8;
                end
            end
            PH_EXT:
            begin
                flen_next = {flen_reg[d][55:0], b};
                hidx_next = hidx_reg[d] - 4'd1;
                if (hidx_next == 4'd0)
                    do_after_len = 1'b1;
            end
            PH_KEY:
            begin
                key_next  = {key_reg[d][23:0], b};
                hidx_next = hidx_reg[d] - 4'd1;
                if (hidx_next == 4'd0)
                    do_finish = 1'b1;
            end
            default:
            begin
                // payload byte: unmask, then classify by frame kind and offset
                case (off_cur[1:0])
                    2'd0:    keyb = key_reg[d][31:24];
                    2'd1:    keyb = key_reg[d][23:16];
                    2'd2:    keyb = key_reg[d][15:8];
                    default: keyb = key_reg[d][7:0];
                endcase
                c  = b ^ (msk_reg[d] ? keyb : 8'd0);
                ev = EV_OTHER;
                if (samp_reg[d] && (off_cur < 31'(SAMPLE_MAX)))
                begin
                    ev = EV_TEXT;
                    if (c < CTRL_LIMIT && c != CHAR_TAB && c != CHAR_LF && c != CHAR_CR)
                        c = CHAR_DOT;
                end
                else if (fop_reg[d] == OP_CLOSE && (|flen_reg[d][63:1]))
                begin
                    if (off_cur == 31'd0)
                        chi_next = c;
                    else if (off_cur == 31'd1)
                    begin
                        ev   = EV_CLOSE;
                        code = {chi_reg[d], c};
                    end
                    else if (off_cur < 31'(REASON_MAX + 2))
                    begin
                        ev = EV_REASON;
                        if (c < CTRL_LIMIT && c != CHAR_TAB)
                            c = CHAR_DOT;
                    end
                end
                obyte    = c;
                off_inc  = {1'b0, off_cur} + 32'd1;
                off_next = off_inc[30:0];
                if (off_inc >= flen_reg[d][31:0])
                begin
                    fend       = 1'b1;
                    phase_next = PH_FIRST;
                    hidx_next  = 4'd0;
                end
            end
        endcase

        if (do_after_len && msk_next)
        begin
            phase_next = PH_KEY;
            hidx_next  = 4'd4;
        end
        else if (do_after_len)
            do_finish = 1'b1;

        eff_op = (fop_next != 4'd0) ? fop_next : lop_next;

        if (do_finish)
        begin
            if (|flen_next[63:31])
            begin
                halted_next = 1'b1;
                ev          = EV_BAD_LEN;
            end
            else
            begin
                if (fop_next != 4'd0)
                    lop_next = fop_next;
                frames_next = frames_reg + 32'd1;
                if (msk_next)
                    mcnt_next = mcnt_reg + 32'd1;
                total_sum  = {1'b0, total_reg} + {1'b0, flen_next[30:0]};
                total_next = total_sum[31] ? LEN_LIMIT : total_sum[30:0];
                off_next   = 31'd0;
                samp_next  = 1'b0;
                if (eff_op == OP_TEXT && (|flen_next[30:0]) && samples_reg < limit_reg)
                begin
                    samp_next    = 1'b1;
                    samples_next = samples_reg + 11'd1;
                end
                hidx_next = 4'd0;
                ev        = EV_HDR_DONE;
                if (flen_next[30:0] == 31'd0)
                begin
                    phase_next = PH_FIRST;
                    fend       = 1'b1;
                end
                else
                    phase_next = PH_PAY;
            end
        end

        res.event_res      = ev;
        res.dir_out        = d;
        res.opcode         = eff_op;
        res.fin            = fin_next;
        res.masked         = msk_next;
        res.payload_length = (|flen_next[63:31]) ? LEN_LIMIT : flen_next[30:0];
        res.out_byte       = obyte;
        res.close_code     = code;
        res.frame_count    = frames_next;
        res.masked_count   = mcnt_next;
        res.payload_total  = total_next;
        res.frame_end      = fend;

        if (halted_reg)
        begin
            halted_next  = 1'b1;
            frames_next  = frames_reg;
            mcnt_next    = mcnt_reg;
            total_next   = total_reg;
            samples_next = samples_reg;
            res          = '0;
            res.event_res     = EV_IGNORED;
            res.dir_out       = d;
            res.frame_count   = frames_reg;
            res.masked_count  = mcnt_reg;
            res.payload_total = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i] <= PH_FIRST;
                hidx_reg[i]  <= 4'd0;
                flen_reg[i]  <= 64'd0;
                key_reg[i]   <= 32'd0;
                off_reg[i]   <= 31'd0;
                fop_reg[i]   <= 4'd0;
                lop_reg[i]   <= 4'd0;
                fin_reg[i]   <= 1'b0;
                msk_reg[i]   <= 1'b0;
                samp_reg[i]  <= 1'b0;
                chi_reg[i]   <= 8'd0;
            end
            frames_reg  <= 32'd0;
            mcnt_reg    <= 32'd0;
            total_reg   <= 31'd0;
            samples_reg <= 11'd0;
            halted_reg  <= 1'b0;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            if (sample_limit_we)
                limit_reg <= sample_limit_wdata;
            if (fire)
            begin
                if (!halted_reg)
                begin
                    phase_reg[d] <= phase_next;
                    hidx_reg[d]  <= hidx_next;
                    flen_reg[d]  <= flen_next;
                    key_reg[d]   <= key_next;
                    off_reg[d]   <= off_next;
                    fop_reg[d]   <= fop_next;
                    lop_reg[d]   <= lop_next;
                    fin_reg[d]   <= fin_next;
                    msk_reg[d]   <= msk_next;
                    samp_reg[d]  <= samp_next;
                    chi_reg[d]   <= chi_next;
                end
                frames_reg  <= frames_next;
                mcnt_reg    <= mcnt_next;
                total_reg   <= total_next;
                samples_reg <= samples_next;
                halted_reg  <= halted_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_halt_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        fire && halted_reg |-> res.event_res == EV_IGNORED)
        else $error("byte processed while halted");

    a_bad_len_halts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.event_res == EV_BAD_LEN |=> halted_reg)
        else $error("bad length did not halt parser");

    a_end_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !halted_reg && res.frame_end |=> phase_reg[$past(d)] == PH_FIRST)
        else $error("frame end left parser mid-frame");
`endif

endmodule

// ----- sv/websocket_frame_parser.sv -----
// top level of the websocket frame parser
// Parses a byte stream of websocket frames, one byte per transfer, with
// independent parse state for each of two directions. Every accepted byte
// yields exactly one result: a header event, a payload event (text sample,
// close code, close reason, other payload), a bad-length event or, after a bad
// length, an ignored event until reset. Throughput is one byte per clock
// while neither queue stalls: a two-entry input queue feeds a parse stage
// that writes a two-entry result queue, so input and output stall
// independently. Each byte is registered in the input queue and its result
// in the result queue. sample_limit is written through sample_limit_we/wdata
// and caps how many text frames are sampled; it resets to 4.
module websocket_frame_parser #(
    parameter int SAMPLE_MAX = 256,
    parameter int REASON_MAX = 123
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        sample_limit_we,
    input  logic [10:0] sample_limit_wdata,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        direction,
    input  logic [7:0]  data_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_res,
    output logic        dir_out,
    output logic [3:0]  opcode,
    output logic        fin,
    output logic        masked,
    output logic [30:0] payload_length,
    output logic [7:0]  out_byte,
    output logic [15:0] close_code,
    output logic [31:0] frame_count,
    output logic [31:0] masked_count,
    output logic [30:0] payload_total,
    output logic        frame_end
);
    import wsfp_pkg::*;

    item_t   item_in, item_q;
    logic    item_valid, item_take;
    logic    res_write, res_full;
    result_t res_new, res_head;

    assign item_in.direction = direction;
    assign item_in.data_byte = data_byte;

    // front: buffer incoming bytes
    wsfp_inq u_inq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item_out   (item_q)
    );

    // back: parse one byte per cycle whenever a byte is queued and the result queue has room
    wsfp_parse #(
        .SAMPLE_MAX (SAMPLE_MAX),
        .REASON_MAX (REASON_MAX)
    ) u_parse (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample_limit_we    (sample_limit_we),
        .sample_limit_wdata (sample_limit_wdata),
        .item_valid         (item_valid),
        .item               (item_q),
        .item_take          (item_take),
        .res_full           (res_full),
        .res_write          (res_write),
        .res                (res_new)
    );

    // results wait here until popped
    wsfp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_write (res_write),
        .res_in    (res_new),
        .res_full  (res_full),
        .empty     (empty),
        .pop       (pop),
        .res_out   (res_head)
    );

    assign event_res      = res_head.event_res;
    assign dir_out        = res_head.dir_out;
    assign opcode         = res_head.opcode;
    assign fin            = res_head.fin;
    assign masked         = res_head.masked;
    assign payload_length = res_head.payload_length;
    assign out_byte       = res_head.out_byte;
    assign close_code     = res_head.close_code;
    assign frame_count    = res_head.frame_count;
    assign masked_count   = res_head.masked_count;
    assign payload_total  = res_head.payload_total;
    assign frame_end      = res_head.frame_end;

endmodule

// ----- tb/tb_websocket_frame_parser.sv -----
// self-checking testbench for the websocket frame parser
module tb_websocket_frame_parser;
    import wsfp_pkg::*;

    localparam int SAMPLE_CAP = 256;
    localparam int REASON_CAP = 123;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_limit_we = 1'b0;
    logic [10:0] sample_limit_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic        direction = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    result_t     got;

    websocket_frame_parser dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample_limit_we    (sample_limit_we),
        .sample_limit_wdata (sample_limit_wdata),
        .push               (push),
        .full               (full),
        .direction          (direction),
        .data_byte          (data_byte),
        .empty              (empty),
        .pop                (pop),
        .event_res          (got.event_res),
        .dir_out            (got.dir_out),
        .opcode             (got.opcode),
        .fin                (got.fin),
        .masked             (got.masked),
        .payload_length     (got.payload_length),
        .out_byte           (got.out_byte),
        .close_code         (got.close_code),
        .frame_count        (got.frame_count),
        .masked_count       (got.masked_count),
        .payload_total      (got.payload_total),
        .frame_end          (got.frame_end)
    );

    always #1 clk = ~clk;

    // stream bytes waiting to be sent, and per-direction build queues
    item_t   byte_stream[$];
    item_t   dir_q0[$];
    item_t   dir_q1[$];
    result_t parse_expect[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      pop_stall_pct = 0;
    bit      hold_send = 1'b0;

    // parser state mirror
    phase_t      ph[2];
    logic [3:0]  hidx[2];
    logic [63:0] flen[2];
    logic [31:0] mkey[2];
    logic [30:0] poff[2];
    logic [3:0]  fop[2];
    logic [3:0]  lop[2];
    logic [1:0]  flags[2];
    bit          sampling[2];
    logic [7:0]  close_hi[2];
    logic [31:0] nframes;
    logic [31:0] nmasked;
    logic [63:0] nbytes;
    logic [10:0] ntaken;
    logic [10:0] limit;
    bit          halted;

    function automatic logic [3:0] eff_op(int d);
        return (fop[d] == 4'h0) ? lop[d] : fop[d];
    endfunction

    function automatic logic [30:0] sat31(logic [63:0] v);
        return (v > {33'b0, LEN_LIMIT}) ? LEN_LIMIT : v[30:0];
    endfunction

    function automatic result_t mk(logic [2:0] ev, int d, logic [7:0] b,
                                   logic [15:0] code, logic fe);
        result_t r;
        r.event_res      = ev;
        r.dir_out        = d[0];
        r.opcode         = eff_op(d);
        r.fin            = flags[d][0];
        r.masked         = flags[d][1];
        r.payload_length = sat31(flen[d]);
        r.out_byte       = b;
        r.close_code     = code;
        r.frame_count    = nframes;
        r.masked_count   = nmasked;
        r.payload_total  = sat31(nbytes);
        r.frame_end      = fe;
        return r;
    endfunction

    function automatic result_t close_header(int d);
        if (flen[d] > {33'b0, LEN_LIMIT})
        begin
            halted = 1'b1;
            return mk(EV_BAD_LEN, d, 8'h00, 16'h0, 1'b0);
        end
        if (fop[d] != 4'h0)
            lop[d] = fop[d];
        nframes++;
        if (flags[d][1])
            nmasked++;
        nbytes = nbytes + flen[d];
        if (nbytes > {33'b0, LEN_LIMIT})
            nbytes = {33'b0, LEN_LIMIT};
        poff[d] = '0;
        sampling[d] = 1'b0;
        if (eff_op(d) == OP_TEXT && flen[d] != 0 && ntaken < limit)
        begin
            sampling[d] = 1'b1;
            ntaken++;
        end
        hidx[d] = '0;
        if (flen[d] == 0)
        begin
            ph[d] = PH_FIRST;
            return mk(EV_HDR_DONE, d, 8'h00, 16'h0, 1'b1);
        end
        ph[d] = PH_PAY;
        return mk(EV_HDR_DONE, d, 8'h00, 16'h0, 1'b0);
    endfunction

    function automatic result_t length_known(int d);
        if (flags[d][1])
        begin
            ph[d] = PH_KEY;
            hidx[d] = 4'd4;
            return mk(EV_HDR_BYTE, d, 8'h00, 16'h0, 1'b0);
        end
        return close_header(d);
    endfunction

    // one byte in, one expected result out
    function automatic result_t parse_byte(int d, logic [7:0] b);
        result_t     r;
        logic [31:0] off;
        logic [31:0] nxt;
        logic [7:0]  k;
        logic [7:0]  c;
        logic [2:0]  ev;
        logic [15:0] code;
        logic        fe;
        if (halted)
        begin
            r = '0;
            r.event_res     = EV_IGNORED;
            r.dir_out       = d[0];
            r.frame_count   = nframes;
            r.masked_count  = nmasked;
            r.payload_total = sat31(nbytes);
            return r;
        end
        case (ph[d])
            PH_FIRST:
            begin
                flags[d]    = {1'b0, b[7]};
                fop[d]      = b[3:0];
                flen[d]     = '0;
                mkey[d]     = '0;
                poff[d]     = '0;
                sampling[d] = 1'b0;
                ph[d]       = PH_LEN;
                return mk(EV_HDR_BYTE, d, 8'h00, 16'h0, 1'b0);
            end
            PH_LEN:
            begin
                if (b[7])
                    flags[d][1] = 1'b1;
                if (b[6:0] < LEN7_EXT16)
                begin
                    flen[d] = {57'b0, b[6:0]};
                    return length_known(d);
                end
                ph[d]   = PH_EXT;
                hidx[d] = (b[6:0] == LEN7_EXT16) ? 4'd2 : 4'd8;
                return mk(EV_HDR_BYTE, d, 8'h00, 16'h0, 1'b0);
            end
            PH_EXT:
            begin
                flen[d] = {flen[d][55:0], b};
                hidx[d]--;
                if (hidx[d] == 0)
                    return length_known(d);
                return mk(EV_HDR_BYTE, d, 8'h00, 16'h0, 1'b0);
            end
            PH_KEY:
            begin
                mkey[d] = {mkey[d][23:0], b};
                hidx[d]--;
                if (hidx[d] == 0)
                    return close_header(d);
                return mk(EV_HDR_BYTE, d, 8'h00, 16'h0, 1'b0);
            end
            default:
            begin
                off  = {1'b0, poff[d]};
                k    = flags[d][1] ? mkey[d][(24 - 8 * off[1:0]) +: 8] : 8'h00;
                c    = b ^ k;
                ev   = EV_OTHER;
                code = '0;
                fe   = 1'b0;
                if (sampling[d] && off < SAMPLE_CAP)
                begin
                    ev = EV_TEXT;
                    if (c < CTRL_LIMIT && c != CHAR_TAB && c != CHAR_LF && c != CHAR_CR)
                        c = CHAR_DOT;
                end
                else if (fop[d] == OP_CLOSE && flen[d] >= 2)
                begin
                    if (off == 0)
                        close_hi[d] = c;
                    else if (off == 1)
                    begin
                        ev   = EV_CLOSE;
                        code = {close_hi[d], c};
                    end
                    else if (off - 32'd2 < REASON_CAP)
                    begin
                        ev = EV_REASON;
                        if (c < CTRL_LIMIT && c != CHAR_TAB)
                            c = CHAR_DOT;
                    end
                end
                nxt = off + 32'd1;
                poff[d] = nxt[30:0];
                if ({32'b0, nxt} >= flen[d])
                begin
                    fe      = 1'b1;
                    ph[d]   = PH_FIRST;
                    hidx[d] = '0;
                end
                return mk(ev, d, c, code, fe);
            end
        endcase
    endfunction

    // monitor: check popped results and model pushed bytes at the rising edge
    always @(posedge clk)
    begin
        result_t want;
        if (pop && !empty)
        begin
            if (parse_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = parse_expect.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t\n  exp %p\n  got %p", $time, want, got);
                end
            end
        end
        if (push && !full)
        begin
            parse_expect.push_back(parse_byte(direction, data_byte));
            void'(byte_stream.pop_front());
        end
    end

    // driver: change inputs at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && !hold_send && byte_stream.size() != 0
            && $urandom_range(99) >= send_idle_pct)
        begin
            push      <= 1'b1;
            direction <= byte_stream[0].direction;
            data_byte <= byte_stream[0].data_byte;
        end
        else
            push <= 1'b0;
        pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic add_byte(int d, logic [7:0] b);
        item_t it;
        it.direction = d[0];
        it.data_byte = b;
        if (d == 0)
            dir_q0.push_back(it);
        else
            dir_q1.push_back(it);
    endtask

    // interleave the two direction streams at random
    task automatic interleave();
        while (dir_q0.size() != 0 || dir_q1.size() != 0)
        begin
            if (dir_q1.size() == 0 || (dir_q0.size() != 0 && $urandom_range(1) == 0))
                byte_stream.push_back(dir_q0.pop_front());
            else
                byte_stream.push_back(dir_q1.pop_front());
        end
    endtask

    // build one frame with the given length encoding and random flag bits, key and content
    task automatic build_frame(int d, int plen, logic [3:0] op, logic do_mask,
                               logic [63:0] enc_len, int enc);
        logic [31:0] key;
        logic [7:0]  b;
        key = $urandom;
        add_byte(d, {$urandom_range(1) == 1, 3'($urandom_range(7)), op});
        if (enc == 0)
            add_byte(d, {do_mask, enc_len[6:0]});
        else if (enc == 1)
        begin
            add_byte(d, {do_mask, 7'd126});
            add_byte(d, enc_len[15:8]);
            add_byte(d, enc_len[7:0]);
        end
        else
        begin
            add_byte(d, {do_mask, 7'd127});
            for (int i = 7; i >= 0; i--)
                add_byte(d, enc_len[i*8 +: 8]);
        end
        if (do_mask)
            for (int i = 3; i >= 0; i--)
                add_byte(d, key[i*8 +: 8]);
        for (int i = 0; i < plen; i++)
        begin
            // control characters are common so the sanitizer gets exercised
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(31)) : 8'($urandom);
            add_byte(d, b);
        end
    endtask

    task automatic random_frame(int d, bit allow_long);
        int          plen;
        int          enc;
        int          pick;
        logic [3:0]  op;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2: op = OP_TEXT;
            3:       op = 4'h0;
            4, 5:    op = OP_CLOSE;
            6:       op = 4'h2;
            7:       op = 4'h9;
            default: op = 4'($urandom);
        endcase
        if (allow_long && $urandom_range(15) == 0)
            plen = $urandom_range(300, 126);
        else if ($urandom_range(4) == 0)
            plen = $urandom_range(1, 0);
        else
            plen = $urandom_range(20);
        if (plen >= 126)
            enc = $urandom_range(2, 1);
        else
            enc = ($urandom_range(5) == 0) ? $urandom_range(2, 1) : 0;
        build_frame(d, plen, op, $urandom_range(1), plen, enc);
    endtask

    task automatic random_traffic(int n_items, bit allow_long);
        while (dir_q0.size() + dir_q1.size() < n_items)
        begin
            random_frame($urandom_range(1), allow_long);
            // occasional stray byte added to direction 1
            if ($urandom_range(19) == 0)
                add_byte(1, 8'($urandom));
        end
        // merge the two direction queues into the byte stream
        interleave();
    endtask

    task automatic write_limit(logic [10:0] v);
        @(negedge clk);
        sample_limit_we    <= 1'b1;
        sample_limit_wdata <= v;
        limit = v;
        @(negedge clk);
        sample_limit_we <= 1'b0;
    endtask

    // sender stops until every result of the stream so far has come back
    task automatic drain();
        wait (byte_stream.size() == 0 && parse_expect.size() == 0);
        hold_send = 1'b1;
        repeat (6) @(posedge clk);
        hold_send = 1'b0;
    endtask

    initial
    begin
        for (int d = 0; d < 2; d++)
        begin
            ph[d] = PH_FIRST; hidx[d] = '0; flen[d] = '0; mkey[d] = '0;
            poff[d] = '0; fop[d] = '0; lop[d] = '0; flags[d] = '0;
            sampling[d] = 1'b0; close_hi[d] = '0;
        end
        nframes = '0; nmasked = '0; nbytes = '0; ntaken = '0;
        limit = LIMIT_RESET; halted = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: text with control characters, continuation, close cases
        build_frame(0, 0, OP_TEXT, 1'b0, 0, 0);
        add_byte(0, 8'h01); add_byte(0, 8'h06);
        add_byte(0, 8'h00); add_byte(0, 8'h09); add_byte(0, 8'h0a);
        add_byte(0, 8'h0d); add_byte(0, 8'h1f); add_byte(0, 8'hff);
        add_byte(1, 8'h80); add_byte(1, 8'h81);
        add_byte(1, 8'hff); add_byte(1, 8'h00); add_byte(1, 8'h5a); add_byte(1, 8'ha5);
        add_byte(1, 8'h3c);
        add_byte(0, 8'h88); add_byte(0, 8'h01); add_byte(0, 8'h03);
        add_byte(0, 8'h88); add_byte(0, 8'h05);
        add_byte(0, 8'h03); add_byte(0, 8'he8); add_byte(0, 8'h09);
        add_byte(0, 8'h01); add_byte(0, 8'h7f);
        interleave();
        drain();

        write_limit(11'd0);
        random_traffic(300, 1'b0);
        drain();

        write_limit(11'd1024);
        send_idle_pct = 59;
        random_traffic(300, 1'b1);
        drain();

        write_limit(11'd2);
        send_idle_pct = 0;
        pop_stall_pct = 59;
        random_traffic(300, 1'b1);
        drain();

        // direction 1 opens a frame of maximum length so the total saturates
        write_limit(11'd7);
        send_idle_pct = 12;
        pop_stall_pct = 12;
        build_frame(1, 0, 4'h2, 1'b1, 64'h7fffffff, 2);
        for (int i = 0; i < 120; i++)
            add_byte(1, 8'($urandom));
        while (dir_q0.size() < 250)
            random_frame(0, 1'b0);
        interleave();
        drain();

        // bad length on direction 0, then everything is ignored
        send_idle_pct = 30;
        pop_stall_pct = 30;
        build_frame(0, 0, OP_TEXT, $urandom_range(1),
                    {1'b0, 31'($urandom), 32'($urandom) | 32'h80000000}, 2);
        for (int i = 0; i < 40; i++)
            add_byte($urandom_range(1), 8'($urandom));
        interleave();
        wait (byte_stream.size() == 0 && parse_expect.size() == 0);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && parse_expect.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wsfp_pkg.sv
sv/wsfp_inq.sv
sv/wsfp_outq.sv
sv/wsfp_parse.sv
sv/websocket_frame_parser.sv
tb/tb_websocket_frame_parser.sv
